// ----- design/cchacc_pkg.sv -----
`timescale 1ns / 1ps

package cchacc_pkg;

	localparam int NUM_CELLS = 4096;

	// occupancy bitmap is stored as rows of OCC_W flags
	localparam int OCC_W      = 64;
	localparam int BIT_AW     = $clog2(OCC_W);
	localparam int OCC_ROWS   = (NUM_CELLS + OCC_W - 1) / OCC_W;
	localparam int ROW_AW     = (OCC_ROWS > 1) ? $clog2(OCC_ROWS) : 1;
	localparam int MEM_ROWS   = 1 << ROW_AW;
	localparam int CELL_AW    = ROW_AW + BIT_AW;
	localparam int CELL_DEPTH = MEM_ROWS * OCC_W;

	localparam int LC_W     = 7;
	localparam int SC_W     = 7;
	localparam int RC_W     = 11;
	localparam int LAYER_W  = 6;
	localparam int SLICE_W  = 6;
	localparam int ROW_W    = 10;
	localparam int ENERGY_W = 32;
	localparam int TIME_W   = 32;
	localparam int SUM_W    = 40;
	localparam int CNT_W    = 24;
	localparam int STAT_W   = 3;

	localparam int LS_W   = LC_W + SC_W;
	localparam int LSL_W  = LC_W + SLICE_W;
	localparam int FLAT_W = LS_W + ROW_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [LC_W-1:0] LC_RESET = LC_W'(16);
	localparam logic [SC_W-1:0] SC_RESET = SC_W'(16);
	localparam logic [RC_W-1:0] RC_RESET = RC_W'(16);

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [STAT_W-1:0] {
		STAT_ACCEPTED  = 3'd0,
		STAT_ZERO      = 3'd1,
		STAT_BAD_LAYER = 3'd2,
		STAT_BAD_SLICE = 3'd3,
		STAT_BAD_ROW   = 3'd4,
		STAT_BEYOND    = 3'd5,
		STAT_DRAINED   = 3'd6,
		STAT_EMPTY     = 3'd7
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LAYER_COUNT = 2'd0,
		CFG_SLICE_COUNT = 2'd1,
		CFG_ROW_COUNT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INDEX,
		S_LOOKUP,
		S_UPDATE,
		S_DSCAN,
		S_DPICK,
		S_DREAD
	} state_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [SLICE_W-1:0] slice;
		logic [LAYER_W-1:0] layer;
		logic [SUM_W-1:0]   energy;
		logic [CNT_W-1:0]   count;
		logic [TIME_W-1:0]  first_time;
	} cell_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ROW_AW-1:0] row;
		logic [OCC_W-1:0]  wr_data;
	} occ_cmd_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [CELL_AW-1:0] addr;
		cell_t              wr_data;
	} cell_cmd_t;

	function automatic logic [BIT_AW-1:0] lowest_bit(input logic [OCC_W-1:0] v);
		logic [BIT_AW-1:0] r;
		r = '0;
		for (int i = OCC_W - 1; i >= 0; i--) begin
			if (v[i])
				r = BIT_AW'(i);
		end
		return r;
	endfunction

	function automatic logic [ROW_AW-1:0] lowest_row(input logic [MEM_ROWS-1:0] v);
		logic [ROW_AW-1:0] r;
		r = '0;
		for (int i = MEM_ROWS - 1; i >= 0; i--) begin
			if (v[i])
				r = ROW_AW'(i);
		end
		return r;
	endfunction

endpackage

// ----- design/calorimeter_cell_hit_accumulator.sv -----
`timescale 1ns / 1ps
// A deposit passes through the index, lookup and update states and a drain through the scan,
// pick and read states; a rejected deposit answers from lookup, a drain of an empty store from scan.
// in_ready is high only in idle, so a new deposit or drain is taken only once the last one is done;
// it stays low through the index multiply stage and the reads of the cell and bitmap memories.
// Reset clears config to 16/16/16 and the bitmap summary flags at once; no clearing pass.

module calorimeter_cell_hit_accumulator import cchacc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [LAYER_W-1:0]    layer,
	input  logic [SLICE_W-1:0]    slice,
	input  logic [ROW_W-1:0]      row,
	input  logic [ENERGY_W-1:0]   energy,
	input  logic [TIME_W-1:0]     arrival_time,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STAT_W-1:0]     status,
	output logic [LAYER_W-1:0]    cell_layer,
	output logic [SLICE_W-1:0]    cell_slice,
	output logic [ROW_W-1:0]      cell_row,
	output logic [SUM_W-1:0]      energy_sum,
	output logic [CNT_W-1:0]      deposit_count,
	output logic [TIME_W-1:0]     earliest_time,
	output logic                  more_left,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [LC_W-1:0] layer_count_q;
	logic [SC_W-1:0] slice_count_q;
	logic [RC_W-1:0] row_count_q;

	logic [LAYER_W-1:0]  layer_q;
	logic [SLICE_W-1:0]  slice_q;
	logic [ROW_W-1:0]    row_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [TIME_W-1:0]   time_q;
	status_t             status_q;
	logic [LS_W-1:0]     ls_q;
	logic [LSL_W-1:0]    lsl_q;
	logic [CELL_AW-1:0]  idx_q;
	logic [ROW_AW-1:0]   drow_q;
	logic                dother_q;
	logic                more_q;

	logic    out_valid_q;
	status_t out_status_q;
	cell_t   out_cell_q;
	logic    out_more_q;

	occ_cmd_t            occ_cmd;
	logic [OCC_W-1:0]    occ_rd_data;
	logic [MEM_ROWS-1:0] occ_summary;
	cell_cmd_t           cell_cmd;
	cell_t               cell_rd;

	logic    in_acc;
	logic    slot_free;
	status_t chk_status;
	logic [FLAT_W-1:0] flat;
	logic    beyond;

	logic [BIT_AW-1:0] upd_bit;
	logic              was_occ;
	logic [SUM_W:0]    sum_ext;
	cell_t             upd;

	logic [ROW_AW-1:0] scan_row;
	logic              scan_any;
	logic              scan_other;
	logic [BIT_AW-1:0] pick_bit;
	logic [OCC_W-1:0]  pick_rest;
	logic              pick_more;

	logic    res_load;
	status_t res_status;
	cell_t   res_cell;
	logic    res_more;

	cchacc_occ_map u_occ_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (occ_cmd),
		.rd_data (occ_rd_data),
		.summary (occ_summary)
	);

	cchacc_cell_store u_cell_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cell_cmd),
		.rd_data (cell_rd)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// checks in priority order, against the live count registers
	always_comb begin
		if (energy == '0)
			chk_status = STAT_ZERO;
		else if ({1'b0, layer} >= layer_count_q)
			chk_status = STAT_BAD_LAYER;
		else if ({1'b0, slice} >= slice_count_q)
			chk_status = STAT_BAD_SLICE;
		else if ({1'b0, row} >= row_count_q)
			chk_status = STAT_BAD_ROW;
		else
			chk_status = STAT_ACCEPTED;
	end

	assign flat   = FLAT_W'(ls_q) * FLAT_W'(row_q) + FLAT_W'(lsl_q) + FLAT_W'(layer_q);
	assign beyond = (flat >= FLAT_W'(NUM_CELLS));

	// read-modify-write of the addressed cell
	assign upd_bit = idx_q[BIT_AW-1:0];
	assign was_occ = occ_rd_data[upd_bit];
	assign sum_ext = {1'b0, cell_rd.energy} + (SUM_W + 1)'(energy_q);

	always_comb begin
		upd = cell_rd;
		if (was_occ) begin
			upd.energy = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
			if (cell_rd.count != CNT_MAX)
				upd.count = cell_rd.count + CNT_W'(1);
			if (time_q < cell_rd.first_time)
				upd.first_time = time_q;
		end else begin
			upd.row        = row_q;
			upd.slice      = slice_q;
			upd.layer      = layer_q;
			upd.energy     = SUM_W'(energy_q);
			upd.count      = CNT_W'(1);
			upd.first_time = time_q;
		end
	end

	// drain: lowest nonempty row from the summary, then lowest flag in that row
	assign scan_row   = lowest_row(occ_summary);
	assign scan_any   = |occ_summary;
	assign scan_other = |(occ_summary & ~(MEM_ROWS'(1) << scan_row));
	assign pick_bit   = lowest_bit(occ_rd_data);
	assign pick_rest  = occ_rd_data & ~(OCC_W'(1) << pick_bit);
	assign pick_more  = dother_q || (|pick_rest);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc)
					state_d = action ? S_DSCAN : S_INDEX;
			end
			S_INDEX: state_d = S_LOOKUP;
			S_LOOKUP: begin
				if (status_q != STAT_ACCEPTED) begin
					if (slot_free)
						state_d = S_IDLE;
				end else begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			S_DSCAN: begin
				if (scan_any)
					state_d = S_DPICK;
				else if (slot_free)
					state_d = S_IDLE;
			end
			S_DPICK: state_d = S_DREAD;
			S_DREAD: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		occ_cmd    = '0;
		cell_cmd   = '0;
		res_load   = 1'b0;
		res_status = STAT_ACCEPTED;
		res_cell   = '0;
		res_more   = 1'b0;
		case (state_q)
			S_LOOKUP: begin
				if (status_q != STAT_ACCEPTED) begin
					res_load   = slot_free;
					res_status = status_q;
				end else begin
					occ_cmd.rd_en  = 1'b1;
					occ_cmd.row    = idx_q[CELL_AW-1:BIT_AW];
					cell_cmd.rd_en = 1'b1;
					cell_cmd.addr  = idx_q;
				end
			end
			S_UPDATE: begin
				res_load   = slot_free;
				res_status = STAT_ACCEPTED;
				res_cell   = upd;
				// write back only once, on the cycle the result is loaded into the output register
				if (slot_free) begin
					cell_cmd.wr_en   = 1'b1;
					cell_cmd.addr    = idx_q;
					cell_cmd.wr_data = upd;
					occ_cmd.wr_en    = 1'b1;
					occ_cmd.row      = idx_q[CELL_AW-1:BIT_AW];
					occ_cmd.wr_data  = occ_rd_data | (OCC_W'(1) << upd_bit);
				end
			end
			S_DSCAN: begin
				if (scan_any) begin
					occ_cmd.rd_en = 1'b1;
					occ_cmd.row   = scan_row;
				end else begin
					res_load   = slot_free;
					res_status = STAT_EMPTY;
				end
			end
			S_DPICK: begin
				occ_cmd.wr_en   = 1'b1;
				occ_cmd.row     = drow_q;
				occ_cmd.wr_data = pick_rest;
				cell_cmd.rd_en  = 1'b1;
				cell_cmd.addr   = {drow_q, pick_bit};
			end
			S_DREAD: begin
				res_load   = slot_free;
				res_status = STAT_DRAINED;
				res_cell   = cell_rd;
				res_more   = more_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			layer_count_q <= LC_RESET;
			slice_count_q <= SC_RESET;
			row_count_q   <= RC_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LAYER_COUNT: layer_count_q <= cfg_data[LC_W-1:0];
					CFG_SLICE_COUNT: slice_count_q <= cfg_data[SC_W-1:0];
					CFG_ROW_COUNT:   row_count_q   <= cfg_data[RC_W-1:0];
					default: ;
				endcase
			end
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			layer_q  <= layer;
			slice_q  <= slice;
			row_q    <= row;
			energy_q <= energy;
			time_q   <= arrival_time;
			status_q <= chk_status;
			ls_q     <= LS_W'(layer_count_q) * LS_W'(slice_count_q);
			lsl_q    <= LSL_W'(layer_count_q) * LSL_W'(slice);
		end
		if (state_q == S_INDEX) begin
			idx_q <= flat[CELL_AW-1:0];
			if (status_q == STAT_ACCEPTED && beyond)
				status_q <= STAT_BEYOND;
		end
		if (state_q == S_DSCAN) begin
			drow_q   <= scan_row;
			dother_q <= scan_other;
		end
		if (state_q == S_DPICK)
			more_q <= pick_more;
		if (res_load) begin
			out_status_q <= res_status;
			out_cell_q   <= res_cell;
			out_more_q   <= res_more;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign cell_layer    = out_cell_q.layer;
	assign cell_slice    = out_cell_q.slice;
	assign cell_row      = out_cell_q.row;
	assign energy_sum    = out_cell_q.energy;
	assign deposit_count = out_cell_q.count;
	assign earliest_time = out_cell_q.first_time;
	assign more_left     = out_more_q;

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transaction");

	a_last_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DREAD && res_load && !more_q) |-> (occ_summary == '0))
		else $error("drain reported no cells left but bitmap is not empty");

	a_accepted_cell_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STAT_ACCEPTED)
			|-> (out_cell_q.count != '0 && out_cell_q.energy != '0))
		else $error("accepted deposit returned an empty cell");

endmodule

// ----- design/cchacc_occ_map.sv -----
`timescale 1ns / 1ps

module cchacc_occ_map import cchacc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  occ_cmd_t            cmd,
	output logic [OCC_W-1:0]    rd_data,
	output logic [MEM_ROWS-1:0] summary
);

	logic [OCC_W-1:0]    mem [MEM_ROWS];
	logic [OCC_W-1:0]    rd_q;
	logic                rd_nz_q;
	logic [MEM_ROWS-1:0] nonzero_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.row] <= cmd.wr_data;
		if (cmd.rd_en)
			rd_q <= mem[cmd.row];
	end

	// a row whose summary flag is clear reads as empty, so the memory needs no clearing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonzero_q <= '0;
			rd_nz_q   <= 1'b0;
		end else begin
			if (cmd.wr_en)
				nonzero_q[cmd.row] <= |cmd.wr_data;
			if (cmd.rd_en)
				rd_nz_q <= nonzero_q[cmd.row];
		end
	end

	assign rd_data = rd_nz_q ? rd_q : '0;
	assign summary = nonzero_q;

	a_summary_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |=> (nonzero_q[$past(cmd.row)] == $past(|cmd.wr_data)))
		else $error("occupancy summary flag does not follow row write");

endmodule

// ----- design/cchacc_cell_store.sv -----
`timescale 1ns / 1ps

module cchacc_cell_store import cchacc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	output cell_t     rd_data
);

	cell_t mem [CELL_DEPTH];
	cell_t rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[cmd.addr] <= cmd.wr_data;
		if (cmd.rd_en)
			rd_q <= mem[cmd.addr];
	end

	assign rd_data = rd_q;

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("cell store read and write in the same cycle");

endmodule
